// File: design/ps2kbd_pkg.sv
// shared types and constants for the ps2 keyboard event receiver
`default_nettype none

package ps2kbd_pkg;

    localparam int unsigned TimeoutW = 16;
    localparam logic [TimeoutW-1:0] TimeoutReset = 16'd200;

    localparam logic [1:0] KIND_NOKEY   = 2'd0;
    localparam logic [1:0] KIND_PRESS   = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;

    localparam logic [7:0] CODE_EXTENDED = 8'hE0;
    localparam logic [7:0] CODE_RELEASE  = 8'hF0;

    // what the frame receiver hands to the prefix tracker for one sample
    typedef struct packed {
        logic       byte_done;
        logic [7:0] byte_val;
        logic       idle_timeout;
    } t_frame_evt;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] code;
    } t_event;

endpackage

`default_nettype wire

// File: design/ps2kbd_frame.sv
// frame receiver: edge detect, start/data/parity/stop bits, idle timer
`default_nettype none

module ps2kbd_frame (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_valid,
    input  wire                                i_clock_level,
    input  wire                                i_data_level,
    input  wire  [ps2kbd_pkg::TimeoutW-1:0]    i_timeout_ticks,
    output ps2kbd_pkg::t_frame_evt             o_evt
);

    localparam logic [3:0] PH_START  = 4'd0;
    localparam logic [3:0] PH_DATA1  = 4'd1;
    localparam logic [3:0] PH_DATA8  = 4'd8;
    localparam logic [3:0] PH_PARITY = 4'd9;
    localparam logic [3:0] PH_STOP   = 4'd10;

    localparam logic [ps2kbd_pkg::TimeoutW-1:0] IdleMax = '1;

    logic                              r_prev_clk, n_prev_clk;
    logic [3:0]                        r_phase, n_phase;
    logic [7:0]                        r_byte, n_byte;
    logic                              r_parity, n_parity;
    logic [ps2kbd_pkg::TimeoutW-1:0]   r_idle, n_idle;

    logic                              fall;
    logic [ps2kbd_pkg::TimeoutW-1:0]   idle_inc;
    logic [2:0]                        bit_idx;

    assign fall     = r_prev_clk & ~i_clock_level;
    assign idle_inc = r_idle + 1'b1;
    assign bit_idx  = r_phase[2:0] - 3'd1;

    always_comb begin
        n_prev_clk = r_prev_clk;
        n_phase    = r_phase;
        n_byte     = r_byte;
        n_parity   = r_parity;
        n_idle     = r_idle;
        o_evt      = '0;
        o_evt.byte_val = r_byte;
        if (i_valid) begin
            n_prev_clk = i_clock_level;
            if (fall) begin
                n_idle = '0;
                if (r_phase == PH_START) begin
                    if (!i_data_level) begin
                        n_phase  = PH_DATA1;
                        n_byte   = '0;
                        n_parity = 1'b0;
                    end
                end else if (r_phase <= PH_DATA8) begin
                    n_byte[bit_idx] = r_byte[bit_idx] | i_data_level;
                    n_parity        = r_parity ^ i_data_level;
                    n_phase         = r_phase + 4'd1;
                end else if (r_phase == PH_PARITY) begin
                    // odd parity over data and parity bit
                    n_phase = (r_parity ^ i_data_level) ? PH_STOP : PH_START;
                end else if (r_phase == PH_STOP) begin
                    n_phase         = PH_START;
                    o_evt.byte_done = i_data_level;
                end else begin
                    n_phase = PH_START;
                end
            end else if (i_clock_level && r_idle != IdleMax) begin
                n_idle = idle_inc;
                if (idle_inc == i_timeout_ticks) begin
                    if (r_phase != PH_START) begin
                        // timeout inside a frame aborts it
                        n_phase  = PH_START;
                        n_byte   = '0;
                        n_parity = 1'b0;
                    end else begin
                        o_evt.idle_timeout = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_clk <= 1'b1;
            r_phase    <= PH_START;
            r_byte     <= '0;
            r_parity   <= 1'b0;
            r_idle     <= '0;
        end else begin
            r_prev_clk <= n_prev_clk;
            r_phase    <= n_phase;
            r_byte     <= n_byte;
            r_parity   <= n_parity;
            r_idle     <= n_idle;
        end
    end

endmodule

`default_nettype wire

// File: design/ps2kbd_prefix.sv
// prefix tracker: turns e0/f0 prefixes and bytes into press/release events
`default_nettype none

module ps2kbd_prefix (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire ps2kbd_pkg::t_frame_evt i_evt,
    output logic                      o_valid,
    output ps2kbd_pkg::t_event        o_event
);

    localparam logic [1:0] PFX_NONE     = 2'd0;
    localparam logic [1:0] PFX_EXTENDED = 2'd1;
    localparam logic [1:0] PFX_RELEASE  = 2'd2;

    logic [1:0] r_state, n_state;

    always_comb begin
        n_state      = r_state;
        o_valid      = 1'b0;
        o_event.kind = ps2kbd_pkg::KIND_PRESS;
        o_event.code = i_evt.byte_val;
        if (i_evt.byte_done) begin
            priority if (r_state == PFX_RELEASE) begin
                n_state      = PFX_NONE;
                o_valid      = 1'b1;
                o_event.kind = ps2kbd_pkg::KIND_RELEASE;
            end else if (i_evt.byte_val == ps2kbd_pkg::CODE_RELEASE) begin
                n_state = PFX_RELEASE;
            end else if (r_state != PFX_EXTENDED
                         && i_evt.byte_val == ps2kbd_pkg::CODE_EXTENDED) begin
                n_state = PFX_EXTENDED;
            end else begin
                n_state = PFX_NONE;
                o_valid = 1'b1;
            end
        end else if (i_evt.idle_timeout) begin
            // a pending prefix swallows the timeout; unused code acts as none
            if (r_state != PFX_EXTENDED && r_state != PFX_RELEASE) begin
                n_state      = PFX_NONE;
                o_valid      = 1'b1;
                o_event.kind = ps2kbd_pkg::KIND_NOKEY;
                o_event.code = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PFX_NONE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// File: design/ps2kbd_out_buf.sv
// result register with skid entry
`default_nettype none

module ps2kbd_out_buf (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_push,
    input  wire ps2kbd_pkg::t_event   i_data,
    input  wire                       i_pending,
    output logic                      o_can_accept,
    output logic                      o_valid,
    input  wire                       i_ready,
    output ps2kbd_pkg::t_event        o_data
);

    logic                   r_out_valid, r_skid_valid;
    ps2kbd_pkg::t_event     r_out, r_skid;
    logic                   pop;
    logic [1:0]             level;

    assign pop     = r_out_valid & i_ready;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // room left after this edge for the sample in flight and one more
    assign level        = {1'b0, r_out_valid} + {1'b0, r_skid_valid} + {1'b0, i_pending}
                          - {1'b0, pop};
    assign o_can_accept = (level <= 2'd1);

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || pop) begin
            r_out <= r_skid_valid ? r_skid : i_data;
            if (r_skid_valid) begin
                r_skid <= i_data;
            end
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || pop) begin
            r_out_valid  <= r_skid_valid | i_push;
            r_skid_valid <= r_skid_valid & i_push;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

endmodule

`default_nettype wire

// File: design/ps2_keyboard_event_receiver_unit.sv
// top level of the ps2 keyboard event receiver
//
// channel  | direction | handshake              | payload
// ---------+-----------+------------------------+----------------------------
// in       | input     | i_in_valid/o_in_ready  | i_clock_level, i_data_level
// out      | output    | o_out_valid/i_out_ready| o_event_kind, o_key_code
// cfg      | input     | i_cfg_valid/o_cfg_ready| i_timeout_ticks
//
// one line sample per cycle while input ready is high: a sample transfer loads
// the input register, the frame receiver and prefix tracker work on it in the
// next cycle and load the result register at its end.
// synchronous active-low reset returns to idle line state, timeout 200.
// a stalled output fills the skid entry; input ready drops when the entries
// held after this edge plus the sample in flight would fill both entries.
`default_nettype none

module ps2_keyboard_event_receiver_unit (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_in_valid,
    output logic                               o_in_ready,
    input  wire                                i_clock_level,
    input  wire                                i_data_level,
    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output logic [1:0]                         o_event_kind,
    output logic [7:0]                         o_key_code,
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire  [ps2kbd_pkg::TimeoutW-1:0]    i_timeout_ticks
);

    logic                              r_in_valid;
    logic                              r_in_clk, r_in_dat;
    logic [ps2kbd_pkg::TimeoutW-1:0]   r_timeout;
    logic                              in_xfer;
    logic                              can_accept;
    logic                              evt_valid;
    ps2kbd_pkg::t_frame_evt            frame_evt;
    ps2kbd_pkg::t_event                evt, out_evt;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = can_accept;
    assign in_xfer     = i_in_valid & can_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= ps2kbd_pkg::TimeoutReset;
        end else if (i_cfg_valid) begin
            r_timeout <= i_timeout_ticks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_xfer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_clk <= i_clock_level;
            r_in_dat <= i_data_level;
        end
    end

    ps2kbd_frame u_frame (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (r_in_valid),
        .i_clock_level   (r_in_clk),
        .i_data_level    (r_in_dat),
        .i_timeout_ticks (r_timeout),
        .o_evt           (frame_evt)
    );

    ps2kbd_prefix u_prefix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (frame_evt),
        .o_valid (evt_valid),
        .o_event (evt)
    );

    ps2kbd_out_buf u_out_buf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (evt_valid),
        .i_data       (evt),
        .i_pending    (r_in_valid),
        .o_can_accept (can_accept),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_data       (out_evt)
    );

    assign o_event_kind = out_evt.kind;
    assign o_key_code   = out_evt.code;

endmodule

`default_nettype wire

// File: bench/ps2_event_checker.sv
// checker for the ps2 keyboard event receiver: predicts events from line samples and compares
`timescale 1ns / 1ps

module ps2_event_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    input  wire         i_in_ready,
    input  wire         i_clock_level,
    input  wire         i_data_level,
    input  wire         i_out_valid,
    input  wire         i_out_ready,
    input  wire  [1:0]  i_event_kind,
    input  wire  [7:0]  i_key_code,
    input  wire         i_cfg_valid,
    input  wire         i_cfg_ready,
    input  wire  [15:0] i_timeout_ticks,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_predicted
);

    // frame position: waiting for start bit, data bits, parity, stop
    localparam logic [3:0] PHASE_WAIT      = 4'd0;
    localparam logic [3:0] PHASE_FIRST     = 4'd1;
    localparam logic [3:0] PHASE_LAST_DATA = 4'd8;
    localparam logic [3:0] PHASE_PARITY    = 4'd9;
    localparam logic [3:0] PHASE_STOP      = 4'd10;

    localparam logic [1:0] PFX_NONE     = 2'd0;
    localparam logic [1:0] PFX_EXTENDED = 2'd1;
    localparam logic [1:0] PFX_RELEASE  = 2'd2;

    ps2kbd_pkg::t_event expected_events[$];
    ps2kbd_pkg::t_event oldest;
    logic [15:0] timeout_limit;
    logic        line_clk_q;
    logic [3:0]  bit_pos;
    logic [7:0]  rx_byte;
    logic        rx_parity;
    logic [15:0] high_ticks;
    logic [1:0]  prefix;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_predicted  = 0;
    end

    task automatic expect_event(input logic [1:0] kind, input logic [7:0] code);
        ps2kbd_pkg::t_event ev;
        ev.kind = kind;
        ev.code = code;
        expected_events.push_back(ev);
        o_predicted++;
    endtask

    task automatic predict_sample(input logic c, input logic d);
        if (line_clk_q && !c) begin
            high_ticks = '0;
            case (bit_pos)
                PHASE_WAIT: begin
                    // a high data line at an edge is not a start bit
                    if (!d) begin
                        bit_pos   = PHASE_FIRST;
                        rx_byte   = '0;
                        rx_parity = 1'b0;
                    end
                end
                PHASE_PARITY: begin
                    bit_pos = (rx_parity ^ d) ? PHASE_STOP : PHASE_WAIT;
                end
                PHASE_STOP: begin
                    bit_pos = PHASE_WAIT;
                    if (d) begin
                        if (prefix == PFX_RELEASE) begin
                            prefix = PFX_NONE;
                            expect_event(ps2kbd_pkg::KIND_RELEASE, rx_byte);
                        end else if (rx_byte == ps2kbd_pkg::CODE_RELEASE) begin
                            prefix = PFX_RELEASE;
                        end else if (prefix != PFX_EXTENDED
                                     && rx_byte == ps2kbd_pkg::CODE_EXTENDED) begin
                            prefix = PFX_EXTENDED;
                        end else begin
                            prefix = PFX_NONE;
                            expect_event(ps2kbd_pkg::KIND_PRESS, rx_byte);
                        end
                    end
                end
                default: begin
                    if (bit_pos <= PHASE_LAST_DATA) begin
                        rx_byte[bit_pos - PHASE_FIRST] = d;
                        rx_parity = rx_parity ^ d;
                        bit_pos   = bit_pos + 4'd1;
                    end else begin
                        bit_pos = PHASE_WAIT;
                    end
                end
            endcase
        end else if (c && high_ticks != 16'hFFFF) begin
            high_ticks = high_ticks + 16'd1;
            if (high_ticks == timeout_limit) begin
                if (bit_pos != PHASE_WAIT) begin
                    // timeout inside a frame drops it silently
                    bit_pos   = PHASE_WAIT;
                    rx_byte   = '0;
                    rx_parity = 1'b0;
                end else if (prefix != PFX_EXTENDED && prefix != PFX_RELEASE) begin
                    prefix = PFX_NONE;
                    expect_event(ps2kbd_pkg::KIND_NOKEY, 8'h00);
                end
            end
        end
        line_clk_q = c;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            timeout_limit = ps2kbd_pkg::TimeoutReset;
            line_clk_q    = 1'b1;
            bit_pos       = PHASE_WAIT;
            rx_byte       = '0;
            rx_parity     = 1'b0;
            high_ticks    = '0;
            prefix        = PFX_NONE;
            expected_events.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_events.size() == 0) begin
                    $display("%0t: unexpected event, expected none, got kind %0d code %02h",
                             $time, i_event_kind, i_key_code);
                    o_fail_count++;
                end else begin
                    oldest = expected_events.pop_front();
                    if (i_event_kind !== oldest.kind) begin
                        $display("%0t: event kind mismatch, expected %0d, got %0d",
                                 $time, oldest.kind, i_event_kind);
                        o_fail_count++;
                    end
                    if (i_key_code !== oldest.code) begin
                        $display("%0t: key code mismatch, expected %02h, got %02h",
                                 $time, oldest.code, i_key_code);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_sample(i_clock_level, i_data_level);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                timeout_limit = i_timeout_ticks;
            end
        end
        o_pending = expected_events.size();
    end

endmodule

// File: bench/tb.sv
// testbench top: drives ps2 line samples and timeout writes, gives the verdict
`timescale 1ns / 1ps

module tb;

    localparam int QUIET_LIMIT = 5000;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        in_valid      = 1'b0;
    logic        in_ready;
    logic        clock_level   = 1'b1;
    logic        data_level    = 1'b1;
    logic        out_valid;
    logic        out_ready     = 1'b1;
    logic [1:0]  event_kind;
    logic [7:0]  key_code;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [15:0] timeout_ticks = ps2kbd_pkg::TimeoutReset;

    int          fail_count;
    int          pending;
    int          predicted;

    bit          in_gaps     = 1'b1;
    bit          out_stalls  = 1'b1;
    int          hi_max      = 1;
    int          n_samples   = 0;
    int          quiet_cycles = 0;
    logic [15:0] timeout_now = ps2kbd_pkg::TimeoutReset;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    ps2_keyboard_event_receiver_unit u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_clock_level   (clock_level),
        .i_data_level    (data_level),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_event_kind    (event_kind),
        .o_key_code      (key_code),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_timeout_ticks (timeout_ticks)
    );

    ps2_event_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_clock_level   (clock_level),
        .i_data_level    (data_level),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_event_kind    (event_kind),
        .i_key_code      (key_code),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_timeout_ticks (timeout_ticks),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_predicted     (predicted)
    );

    always @(negedge clk) begin
        out_ready <= (out_stalls && $urandom_range(0, 99) < 36) ? 1'b0 : 1'b1;
    end

    // watchdog: a long run with no transfer on any channel means a hang
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // entered and left just after a falling edge; valid stays up between samples
    task automatic send_sample(input logic c, input logic d);
        while (in_gaps && $urandom_range(0, 99) < 36) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        clock_level <= c;
        data_level  <= d;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        n_samples++;
        @(negedge clk);
    endtask

    // one ps2 bit: clock high, then the falling edge carries the bit
    task automatic send_bit(input logic d);
        int hi;
        int lo;
        hi = $urandom_range(1, hi_max);
        lo = $urandom_range(1, 2);
        repeat (hi) send_sample(1'b1, 1'($urandom_range(0, 1)));
        send_sample(1'b0, d);
        repeat (lo - 1) send_sample(1'b0, 1'($urandom_range(0, 1)));
    endtask

    // n_bits below 11 sends a truncated frame
    task automatic send_frame(input logic [7:0] b, input int n_bits,
                              input logic par_err, input logic stop_err);
        logic [10:0] bits;
        bits = {~stop_err, ~(^b) ^ par_err, b, 1'b0};
        for (int i = 0; i < n_bits; i++) begin
            send_bit(bits[i]);
        end
    endtask

    task automatic send_key(input logic [7:0] code, input logic ext, input logic rel);
        if (ext) begin
            send_frame(ps2kbd_pkg::CODE_EXTENDED, 11, 1'b0, 1'b0);
        end
        if (rel) begin
            send_frame(ps2kbd_pkg::CODE_RELEASE, 11, 1'b0, 1'b0);
        end
        send_frame(code, 11, 1'b0, 1'b0);
    endtask

    task automatic idle_high(input int n);
        repeat (n) send_sample(1'b1, 1'($urandom_range(0, 1)));
    endtask

    // stop sending and wait until every predicted event has been taken
    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_timeout(input logic [15:0] t);
        timeout_ticks <= t;
        cfg_valid     <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        timeout_now = t;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // mostly well-formed key sequences, with broken frames, idle stretches and noise
    task automatic play_keyboard(input int n_goal, input int ev_goal);
        int sent0;
        int ev0;
        int r;
        int lim;
        int err;
        sent0 = n_samples;
        ev0   = predicted;
        lim   = (timeout_now == 16'd0 || timeout_now > 16'd300) ? 300 : timeout_now + 4;
        while (n_samples - sent0 < n_goal || predicted - ev0 < ev_goal) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                send_key(8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else if (r < 65) begin
                send_frame(8'($urandom), 11, 1'b0, 1'b0);
            end else if (r < 73) begin
                err = $urandom_range(0, 1);
                send_frame(8'($urandom), 11, 1'(err), 1'(!err));
            end else if (r < 80) begin
                send_frame(8'($urandom), $urandom_range(1, 10), 1'b0, 1'b0);
            end else if (r < 90) begin
                idle_high($urandom_range(1, lim));
            end else begin
                repeat ($urandom_range(1, 16)) begin
                    send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end
            end
        end
    endtask

    initial begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // first sample after reset is a falling edge with data high: not a start
        send_sample(1'b0, 1'b1);
        // reset timeout of 200 gives one no-key event
        idle_high(201);
        settle();

        write_timeout(16'd6);
        send_key(8'h00, 1'b0, 1'b0);
        send_key(ps2kbd_pkg::CODE_EXTENDED, 1'b1, 1'b0);
        send_key(8'h1C, 1'b1, 1'b1);
        send_key(ps2kbd_pkg::CODE_RELEASE, 1'b0, 1'b1);
        send_frame(8'h3A, 11, 1'b1, 1'b0);
        send_frame(8'h3A, 11, 1'b0, 1'b1);
        // extended prefix pending: timeout keeps it and stays silent
        send_frame(ps2kbd_pkg::CODE_EXTENDED, 11, 1'b0, 1'b0);
        idle_high(8);
        send_frame(8'h12, 11, 1'b0, 1'b0);
        // timeout in the middle of a frame aborts it
        send_frame(8'h5A, 4, 1'b0, 1'b0);
        idle_high(8);
        send_frame(8'h5A, 11, 1'b0, 1'b0);
        idle_high(8);
        settle();

        // zero timeout never fires
        write_timeout(16'd0);
        idle_high(12);
        settle();

        write_timeout(16'd1);
        play_keyboard(40, 2);
        settle();

        // short timeout against longer clock-high phases, no idling on either side
        in_gaps    = 1'b0;
        out_stalls = 1'b0;
        hi_max     = 3;
        write_timeout(16'($urandom_range(2, 6)));
        play_keyboard(130, 3);
        settle();
        in_gaps    = 1'b1;
        out_stalls = 1'b1;

        repeat (16) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
